### hw/rtl/dcal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcal_pkg
// Shared types and constants for dark-channel atmospheric light estimation.
// ----------------------------------------------------------------------------
package dcal_pkg;
    localparam int FIELD_BITS = 16;
    localparam int COUNT_BITS = 9;

    typedef struct packed {
        logic insert;      // shift-insert the input pixel into the ranking
        logic count;       // bump the pixel count
        logic ovf_set;     // mark overflow
        logic sum_start;   // begin accumulation, latch K
        logic sum_step;    // add one ranked entry to the sum
        logic div_start;   // begin division
        logic div_step;    // one quotient bit
        logic clear;       // clear frame state
    } dcal_cmd_t;

    typedef struct packed {
        logic full;        // pixel count at limit
        logic sum_done;    // last entry summed
        logic div_done;    // last quotient bit formed
    } dcal_sts_t;
endpackage

### hw/rtl/dcal_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcal_datapath
// Sorted cell chain, pixel counter, accumulator and serial divider.
// ----------------------------------------------------------------------------
module dcal_datapath #(
    parameter int MAX_PIXELS = 16384,
    parameter int TOP_DEPTH  = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dcal_pkg::dcal_cmd_t          cmd,
    output dcal_pkg::dcal_sts_t          sts,
    input  logic [PIXEL_BITS-1:0]        dark_in,
    input  logic [PIXEL_BITS-1:0]        image_in,
    output logic [dcal_pkg::FIELD_BITS-1:0] atmosphere,
    output logic [dcal_pkg::COUNT_BITS-1:0] search_count,
    output logic                         overflow
);
    import dcal_pkg::*;

    localparam int CW   = $clog2(MAX_PIXELS + 1);
    localparam int SW   = PIXEL_BITS + COUNT_BITS;
    localparam int QW   = $clog2(SW + 1);

    logic [PIXEL_BITS-1:0] dark_reg  [TOP_DEPTH];
    logic [PIXEL_BITS-1:0] image_reg [TOP_DEPTH];
    logic [TOP_DEPTH-1:0]  valid_reg;
    logic [TOP_DEPTH-1:0]  ge;
    logic [CW-1:0]         count_reg;
    logic                  ovf_reg;
    logic [COUNT_BITS-1:0] k_reg;
    logic [COUNT_BITS-1:0] idx_reg;
    logic [SW-1:0]         sum_reg;
    logic [SW-1:0]         quo_reg;
    logic [COUNT_BITS:0]   rem_reg;
    logic [QW-1:0]         bit_reg;
    logic [CW-1:0]         hundreds;
    logic [COUNT_BITS-1:0] k_next;
    logic [COUNT_BITS:0]   trial;

    // stays at or above: entry keeps its slot
    always_comb
    begin
        for (int i = 0; i < TOP_DEPTH; i++)
        begin
            ge[i] = valid_reg[i] && (dark_reg[i] >= dark_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.insert)
        begin
            for (int i = 0; i < TOP_DEPTH; i++)
            begin
                if (!ge[i])
                begin
                    valid_reg[i] <= (i == 0) ? 1'b1 :
                                    (ge[i == 0 ? 0 : i-1] ? 1'b1 :
                                     valid_reg[i == 0 ? 0 : i-1]);
                end
            end
        end
        else if (cmd.sum_step)
        begin
            // summing drains the chain toward entry 0
            for (int i = 0; i < TOP_DEPTH - 1; i++)
            begin
                valid_reg[i] <= valid_reg[i+1];
            end
            valid_reg[TOP_DEPTH-1] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            for (int i = 0; i < TOP_DEPTH; i++)
            begin
                if (!ge[i])
                begin
                    if (i == 0 || ge[i == 0 ? 0 : i-1])
                    begin
                        dark_reg[i]  <= dark_in;
                        image_reg[i] <= image_in;
                    end
                    else
                    begin
                        dark_reg[i]  <= dark_reg[i == 0 ? 0 : i-1];
                        image_reg[i] <= image_reg[i == 0 ? 0 : i-1];
                    end
                end
            end
        end
        else if (cmd.sum_step)
        begin
            for (int i = 0; i < TOP_DEPTH - 1; i++)
            begin
                image_reg[i] <= image_reg[i+1];
            end
        end
    end

    // K = clamp(count / 100); count below 2^15 so a reciprocal multiply is exact
    always_comb
    begin
        hundreds = CW'((32'(count_reg) * 32'd41944) >> 22);
        if (hundreds == '0)
            k_next = COUNT_BITS'(1);
        else if (32'(hundreds) > TOP_DEPTH)
            k_next = COUNT_BITS'(TOP_DEPTH);
        else
            k_next = COUNT_BITS'(hundreds);
        trial = {rem_reg[COUNT_BITS-1:0], quo_reg[SW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.count)
                count_reg <= count_reg + CW'(1);
            if (cmd.ovf_set)
                ovf_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_start)
        begin
            k_reg   <= k_next;
            idx_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            if (valid_reg[0])
                sum_reg <= sum_reg + SW'(image_reg[0]);
            idx_reg <= idx_reg + COUNT_BITS'(1);
        end
        if (cmd.div_start)
        begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
            bit_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, k_reg})
            begin
                rem_reg <= trial - {1'b0, k_reg};
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
            bit_reg <= bit_reg + QW'(1);
        end
    end

    assign sts.full     = (32'(count_reg) >= MAX_PIXELS);
    assign sts.sum_done = (idx_reg == k_reg - COUNT_BITS'(1));
    assign sts.div_done = (32'(bit_reg) == SW - 1);

    assign atmosphere   = quo_reg[FIELD_BITS-1:0];
    assign search_count = k_reg;
    assign overflow     = ovf_reg;
endmodule

### hw/rtl/dcal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcal_ctrl
// Frame controller: insert, sum, divide, present result, clear.
// ----------------------------------------------------------------------------
module dcal_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dcal_pkg::dcal_cmd_t  cmd,
    input  dcal_pkg::dcal_sts_t  sts
);
    import dcal_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_DIV0 = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_LOAD = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       take;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign take      = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.insert  = !sts.full;
                    cmd.count   = !sts.full;
                    cmd.ovf_set = sts.full;
                    if (in_last)
                        state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_start = 1'b1;
                state_next    = S_DIV0;
            end
            S_DIV0:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_done)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

### hw/rtl/dark_channel_atmospheric_light.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_channel_atmospheric_light
// Ranks pixels by dark value in a sorted cell chain and emits the mean image
// value of the top K at the end of each frame.
//
//  channel  | dir | tdata (low bit up)                     | tlast
//  s_axis   | in  | dark_value[15:0], image_value[31:16]   | last_pixel
//  m_axis   | out | atmosphere[15:0], search_count[24:16], | -
//           |     | overflow[25], zero fill to 32          |
//
// One pixel word per cycle while a frame streams in.
// After the last word: K is latched, K ranked entries are summed, the divider
// is loaded and PIXEL_BITS+9 quotient bits are formed; then the result waits
// until taken, and input stalls.
// Reset clears ranking valid bits, the pixel counter and the overflow flag at once.
// ----------------------------------------------------------------------------
module dark_channel_atmospheric_light #(
    parameter int MAX_PIXELS = 16384,
    parameter int TOP_DEPTH  = 256,
    parameter int PIXEL_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // dark_value, image_value
    input  logic        s_axis_tlast,   // last_pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // atmosphere, search_count, overflow
);
    import dcal_pkg::*;

    dcal_cmd_t                 cmd;
    dcal_sts_t                 sts;
    logic [FIELD_BITS-1:0]     atmosphere;
    logic [COUNT_BITS-1:0]     search_count;
    logic                      overflow;

    dcal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dcal_datapath #(
        .MAX_PIXELS (MAX_PIXELS),
        .TOP_DEPTH  (TOP_DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .dark_in      (s_axis_tdata[PIXEL_BITS-1:0]),
        .image_in     (s_axis_tdata[16 +: PIXEL_BITS]),
        .atmosphere   (atmosphere),
        .search_count (search_count),
        .overflow     (overflow)
    );

    assign m_axis_tdata = {6'd0, overflow, search_count, atmosphere};
endmodule
